[rtl/sdbm_pkg.sv]
`default_nettype none

package sdbm_pkg;

  localparam int SLOT_W  = 6;
  localparam int PORT_W  = 16;
  localparam int ADDR_W  = 64;
  localparam int SCORE_W = 2;

  // s_tdata: slot, local_port, remote_port, four address halves, usable
  localparam int IN_BITS   = SLOT_W + 2 * PORT_W + 4 * ADDR_W + 1;
  localparam int IN_DATA_W = ((IN_BITS + 7) / 8) * 8;
  // m_tdata: match_slot, match_score
  localparam int OUT_DATA_W = (((SLOT_W + SCORE_W) + 7) / 8) * 8;

  // Item kind carried on s_tuser
  typedef enum logic {
    OP_LOOKUP = 1'b0,
    OP_WRITE  = 1'b1
  } op_t;

  // One socket entry, also used as the lookup key of a packet
  typedef struct packed {
    logic [ADDR_W-1:0] remote_addr_lo;
    logic [ADDR_W-1:0] remote_addr_hi;
    logic [ADDR_W-1:0] local_addr_lo;
    logic [ADDR_W-1:0] local_addr_hi;
    logic [PORT_W-1:0] remote_port;
    logic [PORT_W-1:0] local_port;
  } entry_t;

  // Controller states
  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_DONE
  } state_t;

endpackage

`default_nettype wire

[rtl/sdbm_table.sv]
`default_nettype none

// Socket table: entry contents and usable bits in two memories,
// one write port each, one shared read address, registered read data.
module sdbm_table #(
  parameter int TABLE_ENTRIES = 64,
  parameter int IDX_W         = 6
) (
  input  wire                  clk,
  input  wire                  data_we,
  input  wire [IDX_W-1:0]      data_waddr,
  input  sdbm_pkg::entry_t     data_wdata,
  input  wire                  use_we,
  input  wire [IDX_W-1:0]      use_waddr,
  input  wire                  use_wdata,
  input  wire                  re,
  input  wire [IDX_W-1:0]      raddr,
  output sdbm_pkg::entry_t     rdata,
  output logic                 rusable
);

  sdbm_pkg::entry_t mem_data [TABLE_ENTRIES];
  logic             mem_use  [TABLE_ENTRIES];

  // entry contents
  always_ff @(posedge clk) begin
    if (data_we) begin
      mem_data[data_waddr] <= data_wdata;
    end
    if (re) begin
      rdata <= mem_data[raddr];
    end
  end

  // usable bits, cleared by a sweep after reset
  always_ff @(posedge clk) begin
    if (use_we) begin
      mem_use[use_waddr] <= use_wdata;
    end
    if (re) begin
      rusable <= mem_use[raddr];
    end
  end

endmodule

`default_nettype wire

[rtl/sdbm_scan.sv]
`default_nettype none

// Match and best-so-far pipeline: read tag align, score stage, best update.
module sdbm_scan #(
  parameter int IDX_W = 6
) (
  input  wire                          clk,
  input  wire                          rst,
  input  wire                          start,
  input  wire                          issue_valid,
  input  wire                          issue_last,
  input  wire [IDX_W-1:0]              issue_idx,
  input  sdbm_pkg::entry_t             key,
  input  sdbm_pkg::entry_t             rdata,
  input  wire                          rusable,
  output logic                         done,
  output logic                         found,
  output logic [IDX_W-1:0]             best_idx,
  output logic [sdbm_pkg::SCORE_W-1:0] best_score
);

  // tag that lines up with the memory read data
  logic             tag_valid;
  logic             tag_last;
  logic [IDX_W-1:0] tag_idx;

  // score stage
  logic                         hit_valid;
  logic                         hit_last;
  logic                         hit;
  logic [IDX_W-1:0]             hit_idx;
  logic [sdbm_pkg::SCORE_W-1:0] hit_score;

  logic                         rp_spec, la_spec, ra_spec;
  logic                         rp_ok, la_ok, ra_ok;
  logic                         hit_next;
  logic [sdbm_pkg::SCORE_W-1:0] score_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      tag_valid <= 1'b0;
    end else begin
      tag_valid <= issue_valid;
    end
    tag_last <= issue_last;
    tag_idx  <= issue_idx;
  end

  // compare entry against packet; zero remote port and address fields are wildcards
  always_comb begin
    rp_spec = rdata.remote_port != '0;
    la_spec = (rdata.local_addr_hi | rdata.local_addr_lo) != '0;
    ra_spec = (rdata.remote_addr_hi | rdata.remote_addr_lo) != '0;
    rp_ok   = !rp_spec || (rdata.remote_port == key.remote_port);
    la_ok   = !la_spec || (rdata.local_addr_hi == key.local_addr_hi &&
                           rdata.local_addr_lo == key.local_addr_lo);
    ra_ok   = !ra_spec || (rdata.remote_addr_hi == key.remote_addr_hi &&
                           rdata.remote_addr_lo == key.remote_addr_lo);
    hit_next = rusable && (rdata.local_port == key.local_port) &&
               rp_ok && la_ok && ra_ok;
    score_next = sdbm_pkg::SCORE_W'(rp_spec) + sdbm_pkg::SCORE_W'(la_spec) +
                 sdbm_pkg::SCORE_W'(ra_spec);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hit_valid <= 1'b0;
    end else begin
      hit_valid <= tag_valid;
    end
    hit_last  <= tag_last;
    hit       <= hit_next;
    hit_idx   <= tag_idx;
    hit_score <= score_next;
  end

  // keep the first entry with the highest score
  always_ff @(posedge clk) begin
    if (rst) begin
      found <= 1'b0;
      done  <= 1'b0;
    end else begin
      done <= hit_valid && hit_last;
      if (start) begin
        found <= 1'b0;
      end else if (hit_valid && hit && (!found || hit_score > best_score)) begin
        found <= 1'b1;
      end
    end
    if (start) begin
      best_idx   <= '0;
      best_score <= '0;
    end else if (hit_valid && hit && (!found || hit_score > best_score)) begin
      best_idx   <= hit_idx;
      best_score <= hit_score;
    end
  end

endmodule

`default_nettype wire

[rtl/socket_demux_best_match_lookup.sv]
`default_nettype none

// Socket demultiplexer with wildcard best-match lookup. Holds TABLE_ENTRIES
// bound sockets in on-chip memory. A write beat (s_tuser = 1) stores one slot
// and answers with found = 0, match_slot = slot written, score 0; slots at or
// beyond TABLE_ENTRIES are dropped but still answered. A lookup beat
// (s_tuser = 0) walks the table once in slot order, one entry read per cycle
// from the table memory, and returns the lowest slot among the entries with
// the most specific fields matched (remote port, local address, remote
// address; zero means any). A miss returns found = 0, slot 0, score 0.
// One item at a time: the next item is taken once the last result is loaded
// into the output register. After reset the usable bits of all TABLE_ENTRIES
// slots are swept to zero, during which s_tready stays low. A finished result
// waits in the output register while the next item is already taken.
module socket_demux_best_match_lookup #(
  parameter int TABLE_ENTRIES = 64
) (
  input  wire                                  clk,
  input  wire                                  rst,
  // s_tdata: slot, local_port, remote_port, local_addr_hi, local_addr_lo,
  //          remote_addr_hi, remote_addr_lo, usable, zero pad
  input  wire                                  s_tvalid,
  output logic                                 s_tready,
  input  wire [sdbm_pkg::IN_DATA_W-1:0]        s_tdata,
  input  wire                                  s_tuser,  // op
  // m_tdata: match_slot, match_score
  output logic                                 m_tvalid,
  input  wire                                  m_tready,
  output logic [sdbm_pkg::OUT_DATA_W-1:0]      m_tdata,
  output logic                                 m_tuser   // found
);

  localparam int IDX_W  = $clog2(TABLE_ENTRIES);
  localparam int WIDE_W = (IDX_W + 1 > sdbm_pkg::SLOT_W) ? IDX_W + 1 : sdbm_pkg::SLOT_W;
  localparam int LAST_IDX = TABLE_ENTRIES - 1;

  // field offsets inside s_tdata
  localparam int LP_LO  = sdbm_pkg::SLOT_W;
  localparam int ENT_W  = $bits(sdbm_pkg::entry_t);
  localparam int USE_AT = LP_LO + ENT_W;

  sdbm_pkg::state_t state, state_next;

  logic [IDX_W-1:0]              cnt;
  sdbm_pkg::entry_t              key;
  logic                          res_found;
  logic [sdbm_pkg::SLOT_W-1:0]   res_slot;
  logic [sdbm_pkg::SCORE_W-1:0]  res_score;

  // unpacked input beat
  logic [sdbm_pkg::SLOT_W-1:0]   in_slot;
  sdbm_pkg::entry_t              in_entry;
  logic                          in_usable;
  logic [WIDE_W-1:0]             in_slot_wide;
  logic                          in_slot_ok;
  logic                          accept;

  // table ports
  logic                          data_we;
  logic                          use_we;
  logic [IDX_W-1:0]              use_waddr;
  logic                          re;
  sdbm_pkg::entry_t              rdata;
  logic                          rusable;

  // scan status
  logic                          scan_done;
  logic                          scan_found;
  logic [IDX_W-1:0]              scan_idx;
  logic [sdbm_pkg::SCORE_W-1:0]  scan_score;
  logic [WIDE_W-1:0]             scan_idx_wide;
  logic                          scan_start;
  logic                          cnt_last;

  assign in_slot      = s_tdata[sdbm_pkg::SLOT_W-1:0];
  assign in_entry     = sdbm_pkg::entry_t'(s_tdata[USE_AT-1:LP_LO]);
  assign in_usable    = s_tdata[USE_AT];
  assign in_slot_wide = WIDE_W'(in_slot);
  assign in_slot_ok   = in_slot_wide < WIDE_W'(TABLE_ENTRIES);
  assign accept       = s_tvalid && s_tready;
  assign cnt_last     = cnt == IDX_W'(LAST_IDX);
  assign scan_idx_wide = WIDE_W'(scan_idx);

  // table writes: item writes from the beat, clear sweep on the usable bits
  assign data_we    = accept && (sdbm_pkg::op_t'(s_tuser) == sdbm_pkg::OP_WRITE) &&
                      in_slot_ok;
  assign use_we     = data_we || (state == sdbm_pkg::ST_CLEAR);
  assign use_waddr  = (state == sdbm_pkg::ST_CLEAR) ? cnt : in_slot_wide[IDX_W-1:0];
  assign re         = state == sdbm_pkg::ST_SCAN;
  assign scan_start = accept && (sdbm_pkg::op_t'(s_tuser) == sdbm_pkg::OP_LOOKUP);

  sdbm_table #(
    .TABLE_ENTRIES (TABLE_ENTRIES),
    .IDX_W         (IDX_W)
  ) u_table (
    .clk        (clk),
    .data_we    (data_we),
    .data_waddr (in_slot_wide[IDX_W-1:0]),
    .data_wdata (in_entry),
    .use_we     (use_we),
    .use_waddr  (use_waddr),
    .use_wdata  ((state == sdbm_pkg::ST_CLEAR) ? 1'b0 : in_usable),
    .re         (re),
    .raddr      (cnt),
    .rdata      (rdata),
    .rusable    (rusable)
  );

  sdbm_scan #(
    .IDX_W (IDX_W)
  ) u_scan (
    .clk         (clk),
    .rst         (rst),
    .start       (scan_start),
    .issue_valid (re),
    .issue_last  (cnt_last),
    .issue_idx   (cnt),
    .key         (key),
    .rdata       (rdata),
    .rusable     (rusable),
    .done        (scan_done),
    .found       (scan_found),
    .best_idx    (scan_idx),
    .best_score  (scan_score)
  );

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= sdbm_pkg::ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // next state and handshake
  always_comb begin
    state_next = state;
    s_tready   = 1'b0;
    unique case (state)
      sdbm_pkg::ST_CLEAR: begin
        if (cnt_last) begin
          state_next = sdbm_pkg::ST_IDLE;
        end
      end
      sdbm_pkg::ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          state_next = (sdbm_pkg::op_t'(s_tuser) == sdbm_pkg::OP_WRITE) ?
                       sdbm_pkg::ST_DONE : sdbm_pkg::ST_SCAN;
        end
      end
      sdbm_pkg::ST_SCAN: begin
        if (cnt_last) begin
          state_next = sdbm_pkg::ST_DRAIN;
        end
      end
      sdbm_pkg::ST_DRAIN: begin
        if (scan_done) begin
          state_next = sdbm_pkg::ST_DONE;
        end
      end
      sdbm_pkg::ST_DONE: begin
        if (!m_tvalid || m_tready) begin
          state_next = sdbm_pkg::ST_IDLE;
        end
      end
      default: state_next = sdbm_pkg::ST_IDLE;
    endcase
  end

  // sweep / scan counter
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (state == sdbm_pkg::ST_CLEAR || state == sdbm_pkg::ST_SCAN) begin
      cnt <= cnt_last ? '0 : cnt + 1'b1;
    end else if (state == sdbm_pkg::ST_IDLE) begin
      cnt <= '0;
    end
  end

  // lookup key and pending result
  always_ff @(posedge clk) begin
    if (accept) begin
      key <= in_entry;
      if (sdbm_pkg::op_t'(s_tuser) == sdbm_pkg::OP_WRITE) begin
        res_found <= 1'b0;
        res_slot  <= in_slot;
        res_score <= '0;
      end
    end else if (state == sdbm_pkg::ST_DRAIN && scan_done) begin
      res_found <= scan_found;
      res_slot  <= scan_found ? scan_idx_wide[sdbm_pkg::SLOT_W-1:0] : '0;
      res_score <= scan_found ? scan_score : '0;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (state == sdbm_pkg::ST_DONE && (!m_tvalid || m_tready)) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
    if (state == sdbm_pkg::ST_DONE && (!m_tvalid || m_tready)) begin
      m_tdata <= sdbm_pkg::OUT_DATA_W'({res_score, res_slot});
      m_tuser <= res_found;
    end
  end

  // a miss or a write reports score zero
  a_miss_zero : assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tuser) |-> (m_tdata[sdbm_pkg::SLOT_W +: sdbm_pkg::SCORE_W] == '0))
    else $error("non-found result with nonzero score");

  // the scan pipeline finishes only while the controller drains it
  a_done_in_drain : assert property (@(posedge clk) disable iff (rst)
    scan_done |-> (state == sdbm_pkg::ST_DRAIN))
    else $error("scan done outside drain");

  // a scan moves only on to the drain
  a_scan_flow : assert property (@(posedge clk) disable iff (rst)
    (state == sdbm_pkg::ST_SCAN) |=>
      (state == sdbm_pkg::ST_SCAN || state == sdbm_pkg::ST_DRAIN))
    else $error("scan left early");

  // no table write from an item while the table is read
  a_no_write_in_scan : assert property (@(posedge clk) disable iff (rst)
    data_we |-> (state == sdbm_pkg::ST_IDLE))
    else $error("table write outside idle");

endmodule

`default_nettype wire

[test/sdbm_lookup_checker.sv]
`default_nettype none

module sdbm_lookup_checker
  import sdbm_pkg::*;
#(
  parameter int ENTRIES = 64
) (
  input  wire                  clk,
  input  wire                  rst,
  input  wire                  s_tvalid,
  input  wire                  s_tready,
  input  wire [IN_DATA_W-1:0]  s_tdata,   // slot, entry_t fields, usable, zero pad
  input  wire                  s_tuser,   // op
  input  wire                  m_tvalid,
  input  wire                  m_tready,
  input  wire [OUT_DATA_W-1:0] m_tdata,   // match_slot, match_score
  input  wire                  m_tuser,   // found
  output int                   mismatches,
  output int                   outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic               found;
    logic [SLOT_W-1:0]  slot;
    logic [SCORE_W-1:0] score;
  } answer_t;

  // Shadow copy of the socket table
  entry_t  bound_entry [ENTRIES];
  logic    bound_live  [ENTRIES];
  answer_t answers_q [$];
  int      fails = 0;

  // Lowest slot among the live entries with the most specific fields matched
  function automatic answer_t best_match(entry_t key);
    answer_t ans;
    int      best;
    int      pts;
    int      i;
    logic    hit;
    ans  = '0;
    best = -1;
    for (i = 0; i < ENTRIES; i++) begin
      hit = bound_live[i] && (bound_entry[i].local_port == key.local_port);
      pts = 0;
      if (hit && bound_entry[i].remote_port != '0) begin
        if (bound_entry[i].remote_port != key.remote_port) hit = 1'b0;
        else pts++;
      end
      if (hit && {bound_entry[i].local_addr_hi, bound_entry[i].local_addr_lo} != '0) begin
        if (bound_entry[i].local_addr_hi != key.local_addr_hi ||
            bound_entry[i].local_addr_lo != key.local_addr_lo) hit = 1'b0;
        else pts++;
      end
      if (hit && {bound_entry[i].remote_addr_hi, bound_entry[i].remote_addr_lo} != '0) begin
        if (bound_entry[i].remote_addr_hi != key.remote_addr_hi ||
            bound_entry[i].remote_addr_lo != key.remote_addr_lo) hit = 1'b0;
        else pts++;
      end
      if (hit && pts > best) begin
        best      = pts;
        ans.found = 1'b1;
        ans.slot  = i[SLOT_W-1:0];
        ans.score = pts[SCORE_W-1:0];
      end
    end
    return ans;
  endfunction

  task automatic check_field(input string what, input int want, input int got);
    if (want != got) begin
      $display("%0t: %s expected %0d got %0d", $time, what, want, got);
      fails++;
    end
  endtask

  // Results first, then the new beat, so a same-edge input never masks an output
  always @(posedge clk) begin : watch
    entry_t            key;
    answer_t           want;
    answer_t           got;
    logic [SLOT_W-1:0] slot;
    int                i;
    if (rst) begin
      for (i = 0; i < ENTRIES; i++) bound_live[i] = 1'b0;
      answers_q.delete();
      outstanding <= 0;
    end else begin
      if (m_tvalid && m_tready) begin
        got.found = m_tuser;
        got.slot  = m_tdata[SLOT_W-1:0];
        got.score = m_tdata[SLOT_W +: SCORE_W];
        if (answers_q.size() == 0) begin
          $display("%0t: unexpected result found=%0d slot=%0d score=%0d",
                   $time, got.found, got.slot, got.score);
          fails++;
        end else begin
          want = answers_q.pop_front();
          check_field("found", int'(want.found), int'(got.found));
          check_field("match_slot", int'(want.slot), int'(got.slot));
          check_field("match_score", int'(want.score), int'(got.score));
        end
      end
      if (s_tvalid && s_tready) begin
        slot = s_tdata[SLOT_W-1:0];
        key  = entry_t'(s_tdata[SLOT_W +: $bits(entry_t)]);
        if (op_t'(s_tuser) == OP_WRITE) begin
          bound_entry[slot] = key;
          bound_live[slot]  = s_tdata[SLOT_W + $bits(entry_t)];
          want       = '0;
          want.slot  = slot;
          answers_q.push_back(want);
        end else begin
          answers_q.push_back(best_match(key));
        end
      end
      outstanding <= answers_q.size();
    end
    mismatches <= fails;
  end

endmodule

`default_nettype wire

[test/socket_demux_best_match_lookup_tb.sv]
`default_nettype none

module socket_demux_best_match_lookup_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import sdbm_pkg::*;

  localparam int ENTRIES      = 64;
  localparam int RANDOM_ITEMS = 900;
  localparam int IDLE_LIMIT   = 4000;
  localparam int DRAIN_CYCLES = 80;
  localparam logic [127:0] ONES = '1;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata = '0;
  logic                  s_tuser = 1'b0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;
  logic                  m_tuser;
  int                    mismatches;
  int                    outstanding;

  always #4 clk = ~clk;

  socket_demux_best_match_lookup #(.TABLE_ENTRIES(ENTRIES)) u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  sdbm_lookup_checker #(.ENTRIES(ENTRIES)) u_check (
    .clk         (clk),
    .rst         (rst),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .s_tuser     (s_tuser),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .m_tuser     (m_tuser),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  // Small pools of ports and addresses so lookups hit bound entries often
  logic [15:0]  port_pool [4];
  logic [127:0] addr_pool [4];
  int           burst_left  = 10;
  int           gap_pending = 0;

  function automatic entry_t make_entry(input logic [15:0] lp, input logic [15:0] rp,
                                        input logic [127:0] la, input logic [127:0] ra);
    entry_t e;
    e.local_port     = lp;
    e.remote_port    = rp;
    e.local_addr_hi  = la[127:64];
    e.local_addr_lo  = la[63:0];
    e.remote_addr_hi = ra[127:64];
    e.remote_addr_lo = ra[63:0];
    return e;
  endfunction

  function automatic logic [15:0] rand_port();
    if ($urandom_range(0, 9) == 0) return 16'($urandom_range(0, 65535));
    return port_pool[$urandom_range(0, 3)];
  endfunction

  // Mostly pool pairs, some with halves from different pool entries, some random
  function automatic logic [127:0] rand_addr();
    int pick;
    pick = $urandom_range(0, 9);
    if (pick == 0) return {$urandom, $urandom, $urandom, $urandom};
    if (pick == 1) return {addr_pool[$urandom_range(0, 3)][127:64],
                           addr_pool[$urandom_range(0, 3)][63:0]};
    return addr_pool[$urandom_range(0, 3)];
  endfunction

  // Sender: bursts of beats separated by random gaps
  task automatic send_item(input op_t op, input logic [SLOT_W-1:0] slot,
                           input entry_t ent, input logic usable);
    logic [IN_DATA_W-1:0] beat;
    beat = '0;
    beat[SLOT_W-1:0] = slot;
    beat[SLOT_W +: $bits(entry_t)] = ent;
    beat[SLOT_W + $bits(entry_t)] = usable;
    repeat (gap_pending) @(posedge clk);
    gap_pending = 0;
    s_tdata  <= beat;
    s_tuser  <= op;
    s_tvalid <= 1'b1;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    burst_left--;
    if (burst_left <= 0) begin
      s_tvalid   <= 1'b0;
      burst_left  = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
      gap_pending = ($urandom_range(0, 1) == 0) ? $urandom_range(1, 4) : $urandom_range(1, 90);
    end
  endtask

  // Receiver: phases of full, light and heavy stalling, plus two long hold-offs
  logic [8:0] rx_phase = '0;
  int         hold_left = 0;
  int         results_seen = 0;

  always @(posedge clk) begin
    if (rst) begin
      m_tready     <= 1'b0;
      rx_phase     <= '0;
      hold_left    <= 0;
      results_seen <= 0;
    end else begin
      rx_phase <= rx_phase + 1'b1;
      if (m_tvalid && m_tready) results_seen <= results_seen + 1;
      if (hold_left != 0) begin
        hold_left <= hold_left - 1;
        m_tready  <= 1'b0;
      end else if (m_tvalid && m_tready && (results_seen == 200 || results_seen == 650)) begin
        hold_left <= 400;
        m_tready  <= 1'b0;
      end else if (rx_phase[8:7] == 2'd0) begin
        m_tready <= 1'b1;
      end else if (rx_phase[8:7] == 2'd1) begin
        m_tready <= ($urandom_range(0, 3) != 0);
      end else begin
        m_tready <= ($urandom_range(0, 1) != 0);
      end
    end
  end

  // Watchdog on cycles without any beat
  int quiet_cycles = 0;

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == IDLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    logic [127:0] la;
    logic [127:0] ra;
    logic [15:0]  rp;
    int           n;

    port_pool[0] = 16'hFFFF;
    port_pool[1] = 16'h0000;
    port_pool[2] = 16'($urandom_range(1, 65534));
    port_pool[3] = 16'($urandom_range(1, 65534));
    addr_pool[0] = ONES;
    addr_pool[1] = {$urandom, $urandom, $urandom, $urandom};
    addr_pool[2] = {$urandom, $urandom, $urandom, $urandom};
    addr_pool[3] = addr_pool[2] ^ 128'h1;

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Fill every slot once, not usable, so no lookup touches unwritten storage
    for (n = 0; n < ENTRIES; n++)
      send_item(OP_WRITE, 6'(n),
                make_entry(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
                           {$urandom, $urandom, $urandom, $urandom},
                           {$urandom, $urandom, $urandom, $urandom}), 1'b0);

    // Directed: one entry per score level, a dead entry, ties, misses
    send_item(OP_WRITE, 6'd0,  make_entry(16'hFFFF, 16'h0000, '0, '0), 1'b1);
    send_item(OP_WRITE, 6'd5,  make_entry(16'hFFFF, 16'hFFFF, '0, '0), 1'b1);
    send_item(OP_WRITE, 6'd10, make_entry(16'hFFFF, 16'hFFFF, ONES, '0), 1'b1);
    send_item(OP_WRITE, 6'd63, make_entry(16'hFFFF, 16'hFFFF, ONES, ONES), 1'b1);
    send_item(OP_WRITE, 6'd7,  make_entry(16'hFFFF, 16'hFFFF, ONES, ONES), 1'b0);
    send_item(OP_LOOKUP, '0, make_entry(16'hFFFF, 16'hFFFF, ONES, ONES), 1'b0);
    send_item(OP_LOOKUP, '0, make_entry(16'hFFFF, 16'hFFFF, ONES, ONES ^ 128'h1), 1'b0);
    send_item(OP_LOOKUP, '0, make_entry(16'hFFFF, 16'hFFFF, ONES >> 1, ONES), 1'b0);
    send_item(OP_LOOKUP, '0, make_entry(16'hFFFF, 16'h0001, ONES, ONES), 1'b0);
    send_item(OP_LOOKUP, '0, make_entry(16'h0000, 16'h0000, '0, '0), 1'b0);
    send_item(OP_LOOKUP, '0, make_entry(16'hFFFE, 16'hFFFF, ONES, ONES), 1'b0);
    // equal full-score entry at a lower slot wins
    send_item(OP_WRITE, 6'd20, make_entry(16'hFFFF, 16'hFFFF, ONES, ONES), 1'b1);
    send_item(OP_LOOKUP, 6'd63, make_entry(16'hFFFF, 16'hFFFF, ONES, ONES), 1'b1);
    // retire the wildcard entry
    send_item(OP_WRITE, 6'd0, make_entry(16'hFFFF, 16'h0000, '0, '0), 1'b0);
    send_item(OP_LOOKUP, '0, make_entry(16'hFFFF, 16'h0001, ONES, ONES), 1'b0);
    // single low or high address bit makes a field specific
    send_item(OP_WRITE, 6'd1, make_entry(16'h0000, 16'h0000, 128'h1, '0), 1'b1);
    send_item(OP_LOOKUP, '0, make_entry(16'h0000, 16'hABCD, 128'h1,
              {$urandom, $urandom, $urandom, $urandom}), 1'b0);
    send_item(OP_WRITE, 6'd2, make_entry(16'h0000, 16'h0000, '0, {1'b1, 127'h0}), 1'b1);
    send_item(OP_LOOKUP, '0, make_entry(16'h0000, 16'h0005, 128'h1, {1'b1, 127'h0}), 1'b0);
    send_item(OP_WRITE, 6'd3, make_entry(16'h0000, 16'h8000, 128'h1, {1'b1, 127'h0}), 1'b1);
    send_item(OP_LOOKUP, '0, make_entry(16'h0000, 16'h8000, 128'h1, {1'b1, 127'h0}), 1'b0);

    // Random: binds with wildcards mixed in, lookups mostly drawn from the same pools
    for (n = 0; n < RANDOM_ITEMS; n++) begin
      if ($urandom_range(0, 9) < 3) begin
        rp = ($urandom_range(0, 2) == 0) ? 16'h0000 : rand_port();
        la = ($urandom_range(0, 2) == 0) ? 128'h0 : rand_addr();
        ra = ($urandom_range(0, 2) == 0) ? 128'h0 : rand_addr();
        send_item(OP_WRITE, 6'($urandom_range(0, ENTRIES - 1)),
                  make_entry(rand_port(), rp, la, ra), ($urandom_range(0, 7) != 0));
      end else if ($urandom_range(0, 9) == 0) begin
        send_item(OP_LOOKUP, 6'($urandom_range(0, 63)),
                  make_entry(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
                             {$urandom, $urandom, $urandom, $urandom},
                             {$urandom, $urandom, $urandom, $urandom}),
                  1'($urandom_range(0, 1)));
      end else begin
        send_item(OP_LOOKUP, 6'($urandom_range(0, 63)),
                  make_entry(rand_port(), rand_port(), rand_addr(), rand_addr()),
                  1'($urandom_range(0, 1)));
      end
    end
    if (gap_pending == 0) s_tvalid <= 1'b0;

    // Drain, then let the block settle
    do @(posedge clk); while (outstanding != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire

[filelist.f]
rtl/sdbm_pkg.sv
rtl/sdbm_table.sv
rtl/sdbm_scan.sv
rtl/socket_demux_best_match_lookup.sv
test/sdbm_lookup_checker.sv
test/socket_demux_best_match_lookup_tb.sv
